// ===== design/gbia_pkg.sv =====
// Package for the grouped bitmap identifier allocator.
// Sizes, field widths, status and mode codes, register indexes and FSM states.
// No dependencies.
package gbia_pkg;

   localparam int MAX_GROUPS        = 8;
   localparam int MAX_IDS_PER_GROUP = 1024;
   localparam int WORD_BITS         = 32;
   localparam int WORDS_PER_GROUP   = (MAX_IDS_PER_GROUP + WORD_BITS - 1) / WORD_BITS;
   localparam int BITMAP_WORDS      = MAX_GROUPS * WORDS_PER_GROUP;

   localparam int GROUP_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam int GCNT_W  = $clog2(MAX_GROUPS + 1);
   localparam int WORD_W  = (WORDS_PER_GROUP > 1) ? $clog2(WORDS_PER_GROUP) : 1;
   localparam int BIT_W   = $clog2(WORD_BITS);
   localparam int ADDR_W  = GROUP_W + WORD_W;

   // field and register widths
   localparam int IPG_W     = 11;
   localparam int NG_W      = 4;
   localparam int ID_W      = 14;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 11;

   localparam logic [IPG_W-1:0] IPG_RESET = IPG_W'(1024);
   localparam logic [NG_W-1:0]  NG_RESET  = NG_W'(8);
   localparam logic [IPG_W-1:0] IPG_MAX   = IPG_W'(MAX_IDS_PER_GROUP);
   localparam logic [NG_W-1:0]  NG_MAX    = NG_W'(MAX_GROUPS);
   localparam logic [ID_W-1:0]  ID_LIMIT  = ID_W'(MAX_GROUPS * MAX_IDS_PER_GROUP);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IDS_PER_GROUP = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_GROUPS_IN_USE = 1'b1;

   // request modes
   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FREE  = 2'd3;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_A_GROUP,
      S_A_READ,
      S_A_CHECK,
      S_F_DIV,
      S_F_READ,
      S_F_CHECK,
      S_DONE
   } state_type;

endpackage

// ===== design/gbia_req_if.sv =====
// Request channel: valid/ready handshake carrying mode and identifier.
// Depends on gbia_pkg.
interface gbia_req_if import gbia_pkg::*; ();
   logic            valid;
   logic            ready;
   logic            mode;
   logic [ID_W-1:0] id_to_free;

   modport source (output valid, output mode, output id_to_free, input ready);
   modport sink   (input valid, input mode, input id_to_free, output ready);
endinterface

// ===== design/gbia_rsp_if.sv =====
// Result channel: valid/ready handshake carrying identifier, status, free count.
// Depends on gbia_pkg.
interface gbia_rsp_if import gbia_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ID_W-1:0]     allocated_id;
   logic [STATUS_W-1:0] status;
   logic [ID_W-1:0]     free_total;

   modport source (output valid, output allocated_id, output status, output free_total,
                   input ready);
   modport sink   (input valid, input allocated_id, input status, input free_total,
                   output ready);
endinterface

// ===== design/grouped_bitmap_id_allocator_top.sv =====
// Grouped bitmap identifier allocator, top level. Depends on gbia_pkg and the channel interfaces.
// Allocate: groups full on their count are skipped, then the words of the first group with room
//   are read in turn until one has a free bit; free: repeated subtract finds the group, then the
//   word is read and its bit cleared; full or out-of-range answers go straight to the result.
//   One request at a time.
// Reset: sync, active high; then a clearing pass over all 256 bitmap RAM words, req not ready.
module grouped_bitmap_id_allocator_top import gbia_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   gbia_req_if.sink              req_chan,
   gbia_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // ---------------------------------------------------------------------------
   // Bitmap RAM: one word per 32 identifiers, group g at words g*WORDS_PER_GROUP on.
   // Registered read. Writes only happen in the check states and the clearing pass.
   // ---------------------------------------------------------------------------
   logic [WORD_BITS-1:0] bitmap_mem [BITMAP_WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_waddr;
   logic [WORD_BITS-1:0] mem_wdata;
   logic [ADDR_W-1:0]    mem_raddr;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bitmap_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= bitmap_mem[mem_raddr];
   end

   // ---------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------
   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   clr_ff, clr_in;
   logic [IPG_W-1:0]    ipg_cfg_ff;
   logic [NG_W-1:0]     ng_cfg_ff;
   logic [IPG_W-1:0]    group_cnt_ff [MAX_GROUPS];
   logic [IPG_W-1:0]    group_cnt_in [MAX_GROUPS];
   logic [ID_W-1:0]     total_ff, total_in;
   logic [GCNT_W-1:0]   grp_ff, grp_in;       // group under scan / group of freed id
   logic [WORD_W-1:0]   word_ff, word_in;     // word within the group
   logic [ID_W-1:0]     base_ff, base_in;     // grp * ipg, built by adding
   logic [ID_W-1:0]     rem_ff, rem_in;       // id - 1 reduced towards index in group
   logic [ID_W-1:0]     res_id_ff, res_id_in;
   logic [STATUS_W-1:0] res_st_ff, res_st_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic [STATUS_W-1:0] rsp_st_ff, rsp_st_in;
   logic [ID_W-1:0]     rsp_free_ff, rsp_free_in;

   // ---------------------------------------------------------------------------
   // Effective configuration and capacity
   // ---------------------------------------------------------------------------
   logic [IPG_W-1:0]      ipg_eff;
   logic [NG_W-1:0]       ng_eff;
   logic [IPG_W+NG_W-1:0] cap_prod;
   logic [ID_W-1:0]       cap;
   logic [ID_W-1:0]       ipg_ext;
   logic [ID_W-1:0]       free_now;

   always_comb begin
      priority if (ipg_cfg_ff == '0) ipg_eff = IPG_W'(1);
      else if (ipg_cfg_ff > IPG_MAX) ipg_eff = IPG_MAX;
      else ipg_eff = ipg_cfg_ff;
      priority if (ng_cfg_ff == '0) ng_eff = NG_W'(1);
      else if (ng_cfg_ff > NG_MAX) ng_eff = NG_MAX;
      else ng_eff = ng_cfg_ff;
   end

   assign cap_prod = ipg_eff * ng_eff;
   assign cap      = cap_prod[ID_W-1:0];
   assign ipg_ext  = ID_W'(ipg_eff);
   assign free_now = (total_ff >= cap) ? '0 : (cap - total_ff);

   // ---------------------------------------------------------------------------
   // Scan and free helpers
   // ---------------------------------------------------------------------------
   logic [GROUP_W-1:0]   grp_idx;
   logic                 grp_full;
   logic                 grp_past_end;
   logic [ID_W-1:0]      word_off;
   logic [ID_W-1:0]      word_remain;
   logic                 last_word;
   logic [WORD_BITS-1:0] active_mask;
   logic [WORD_BITS-1:0] free_bits;
   logic                 any_free;
   logic [BIT_W-1:0]     hit_bit;
   logic [ID_W-1:0]      hit_id;
   logic [ADDR_W-1:0]    free_addr;
   logic                 free_bit_set;
   logic                 req_fire;
   logic                 req_bad;
   logic                 rsp_load;

   assign grp_idx      = grp_ff[GROUP_W-1:0];
   assign grp_full     = group_cnt_ff[grp_idx] >= ipg_eff;
   assign grp_past_end = grp_ff >= GCNT_W'(ng_eff);

   assign word_off    = {{(ID_W-WORD_W-BIT_W){1'b0}}, word_ff, {BIT_W{1'b0}}};
   assign word_remain = ipg_ext - word_off;
   assign last_word   = (word_off + ID_W'(WORD_BITS)) >= ipg_ext;

   // only bits below ids_per_group count as part of the group
   assign active_mask = (word_remain >= ID_W'(WORD_BITS)) ? '1 :
                        ((WORD_BITS'(1) << word_remain[BIT_W-1:0]) - WORD_BITS'(1));
   assign free_bits   = ~rd_data_ff & active_mask;
   assign any_free    = |free_bits;

   always_comb begin
      hit_bit = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (free_bits[b]) begin
            hit_bit = BIT_W'(b);
         end
      end
   end

   assign hit_id = base_ff + word_off + ID_W'(hit_bit) + ID_W'(1);

   assign free_addr    = {grp_idx, rem_ff[BIT_W +: WORD_W]};
   assign free_bit_set = rd_data_ff[rem_ff[BIT_W-1:0]];

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign req_bad        = (req_chan.id_to_free == '0) || (req_chan.id_to_free > cap);
   assign rsp_load       = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   // ---------------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_ff == ADDR_W'(BITMAP_WORDS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_fire) begin
               if (req_chan.mode == MODE_ALLOC) begin
                  state_in = (total_ff >= cap) ? S_DONE : S_A_GROUP;
               end else begin
                  state_in = req_bad ? S_DONE : S_F_DIV;
               end
            end
         end
         S_A_GROUP: begin
            priority if (grp_past_end) state_in = S_DONE;
            else if (!grp_full) state_in = S_A_READ;
         end
         S_A_READ: state_in = S_A_CHECK;
         S_A_CHECK: begin
            priority if (any_free) state_in = S_DONE;
            else if (last_word) state_in = S_A_GROUP;
            else state_in = S_A_READ;
         end
         S_F_DIV: begin
            if (rem_ff < ipg_ext) state_in = S_F_READ;
         end
         S_F_READ:  state_in = S_F_CHECK;
         S_F_CHECK: state_in = S_DONE;
         S_DONE: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------------
   // Datapath and RAM control
   // ---------------------------------------------------------------------------
   always_comb begin
      clr_in       = clr_ff;
      group_cnt_in = group_cnt_ff;
      total_in     = total_ff;
      grp_in       = grp_ff;
      word_in      = word_ff;
      base_in      = base_ff;
      rem_in       = rem_ff;
      res_id_in    = res_id_ff;
      res_st_in    = res_st_ff;
      mem_we       = 1'b0;
      mem_waddr    = clr_ff;
      mem_wdata    = '0;
      mem_raddr    = {grp_idx, word_ff};

      unique case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + ADDR_W'(1);
         end
         S_IDLE: begin
            grp_in    = '0;
            base_in   = '0;
            word_in   = '0;
            res_id_in = '0;
            rem_in    = req_chan.id_to_free - ID_W'(1);
            if (req_chan.mode == MODE_ALLOC) begin
               res_st_in = (total_ff >= cap) ? STATUS_FULL : STATUS_OK;
            end else begin
               res_st_in = req_bad ? STATUS_RANGE : STATUS_OK;
            end
         end
         S_A_GROUP: begin
            word_in = '0;
            priority if (grp_past_end) begin
               res_st_in = STATUS_FULL;
            end else if (grp_full) begin
               grp_in  = grp_ff + GCNT_W'(1);
               base_in = base_ff + ipg_ext;
            end
         end
         S_A_READ: begin
            mem_raddr = {grp_idx, word_ff};
         end
         S_A_CHECK: begin
            priority if (any_free) begin
               mem_we                = 1'b1;
               mem_waddr             = {grp_idx, word_ff};
               mem_wdata             = rd_data_ff | (WORD_BITS'(1) << hit_bit);
               group_cnt_in[grp_idx] = group_cnt_ff[grp_idx] + IPG_W'(1);
               total_in              = total_ff + ID_W'(1);
               res_id_in             = hit_id;
               res_st_in             = STATUS_OK;
            end else if (last_word) begin
               grp_in  = grp_ff + GCNT_W'(1);
               base_in = base_ff + ipg_ext;
            end else begin
               word_in = word_ff + WORD_W'(1);
            end
         end
         S_F_DIV: begin
            if (rem_ff >= ipg_ext) begin
               rem_in = rem_ff - ipg_ext;
               grp_in = grp_ff + GCNT_W'(1);
            end
         end
         S_F_READ: begin
            mem_raddr = free_addr;
         end
         S_F_CHECK: begin
            if (!free_bit_set) begin
               res_st_in = STATUS_FREE;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = free_addr;
               mem_wdata = rd_data_ff & ~(WORD_BITS'(1) << rem_ff[BIT_W-1:0]);
               if (group_cnt_ff[grp_idx] != '0) begin
                  group_cnt_in[grp_idx] = group_cnt_ff[grp_idx] - IPG_W'(1);
               end
               if (total_ff != '0) total_in = total_ff - ID_W'(1);
               res_st_in = STATUS_OK;
            end
         end
         S_DONE: begin
            mem_raddr = {grp_idx, word_ff};
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // ---------------------------------------------------------------------------
   // Output register: takes the finished result when the slot is empty or draining.
   // free_total is read after the counts have settled for this request.
   // ---------------------------------------------------------------------------
   always_comb begin
      rsp_id_in   = rsp_id_ff;
      rsp_st_in   = rsp_st_ff;
      rsp_free_in = rsp_free_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_id_in    = res_id_ff;
         rsp_st_in    = res_st_ff;
         rsp_free_in  = free_now;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.allocated_id = rsp_id_ff;
   assign rsp_chan.status       = rsp_st_ff;
   assign rsp_chan.free_total   = rsp_free_ff;

   // ---------------------------------------------------------------------------
   // Clocked state
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         ipg_cfg_ff   <= IPG_RESET;
         ng_cfg_ff    <= NG_RESET;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int g = 0; g < MAX_GROUPS; g++) begin
            group_cnt_ff[g] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         group_cnt_ff <= group_cnt_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_IDS_PER_GROUP: ipg_cfg_ff <= csr_wdata[IPG_W-1:0];
               CSR_GROUPS_IN_USE: ng_cfg_ff  <= csr_wdata[NG_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      grp_ff      <= grp_in;
      word_ff     <= word_in;
      base_ff     <= base_in;
      rem_ff      <= rem_in;
      res_id_ff   <= res_id_in;
      res_st_ff   <= res_st_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_free_ff <= rsp_free_in;
   end

endmodule

// ===== design/gbia_checker.sv =====
// Port-level checker for the allocator top, plus the bind that attaches it.
// Depends on gbia_pkg and grouped_bitmap_id_allocator_top.
module gbia_checker import gbia_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [ID_W-1:0]     rsp_allocated_id,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [ID_W-1:0]     rsp_free_total
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_allocated_id)
         && $stable(rsp_status) && $stable(rsp_free_total))
      else $error("result changed while stalled");

   // a granted identifier always comes with ok status
   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_allocated_id != '0) |-> rsp_status == STATUS_OK)
      else $error("identifier granted with error status");

   // any error answer grants nothing
   a_error_no_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> rsp_allocated_id == '0)
      else $error("identifier granted on error");

   // free count never beyond the largest capacity
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_free_total <= ID_LIMIT)
      else $error("free total above capacity");

   // no result straight out of reset: the clearing pass runs first
   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid just after reset");

endmodule

bind grouped_bitmap_id_allocator_top gbia_checker u_gbia_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_allocated_id (rsp_chan.allocated_id),
   .rsp_status       (rsp_chan.status),
   .rsp_free_total   (rsp_chan.free_total)
);
